>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Sizes, index widths, the sequencer state type and the bitmap index helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int LEVELS = 8;
  localparam int TOP    = LEVELS - 1;
  localparam int LEAVES = 1 << TOP;
  localparam int NALLOC = (1 << LEVELS) - 1;
  localparam int NSPLIT = (1 << TOP) - 1;

  localparam int OFF_W  = 7;
  localparam int LVL_W  = 3;
  localparam int LINK_W = OFF_W + 1;
  localparam int AIDX_W = 8;
  localparam int SIDX_W = 7;

  // Request commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // A link with its top bit set names no block.
  localparam logic [LINK_W-1:0] NIL = LINK_W'(LEAVES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_SIZE,
    ST_A_SRCH,
    ST_A_MARK,
    ST_A_SPLIT,
    ST_UNL_A,
    ST_UNL_B,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_F_LVL,
    ST_F_CHK,
    ST_F_MRG,
    ST_F_MRG2,
    ST_F_END,
    ST_F_FIN,
    ST_DONE
  } bba_state_t;

  // Bitmap indexes produced by the shared index unit.
  typedef struct packed {
    logic [AIDX_W-1:0] a_self;
    logic [AIDX_W-1:0] a_bud;
    logic [AIDX_W-1:0] a_low;
    logic [SIDX_W-1:0] s_self;
    logic [SIDX_W-1:0] s_up;
  } bba_idx_t;

  // Alloc bitmap index of block bi at level k.
  function automatic logic [AIDX_W-1:0] aidx(input int k, input int bi);
    int base;
    int i;
    base = (1 << LEVELS) - (1 << (LEVELS - k));
    i    = base + (bi & ((1 << (TOP - k)) - 1));
    return (i < NALLOC) ? AIDX_W'(i) : '0;
  endfunction

  // Split bitmap index of block bi at level k (k of one or more).
  function automatic logic [SIDX_W-1:0] sidx(input int k, input int bi);
    int base;
    int i;
    base = (1 << TOP) - (1 << (LEVELS - k));
    i    = base + (bi & ((1 << (TOP - k)) - 1));
    return (i >= 0 && i < NSPLIT) ? SIDX_W'(i) : '0;
  endfunction

endpackage

`default_nettype wire

>>> rtl/buddy_allocator.sv
// ----------------------------------------------------------------------------
// Buddy allocator
// Binary buddy allocator over 128 leaf blocks with per-level free lists.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every step of size rounding, list search,
// split and merge is one pass of the sequencer, and the split and merge steps
// use the shared index unit; each free-list unlink or push is split into an A
// and a B state because a link table takes one write per cycle. A result waits
// in the output register while the next request is taken.
`default_nettype none

module buddy_allocator #(
  parameter int LEAF_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // heap_enabled
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,      // size_bytes[31:0], block_offset[38:32]
  input  wire logic        in_tuser,      // cmd: 0 allocate, 1 free
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata      // ok[0], result_offset[7:1], result_level[10:8]
);

  localparam int OW = bba_pkg::OFF_W;
  localparam int LW = bba_pkg::LVL_W;
  localparam int KW = bba_pkg::LINK_W;
  localparam logic [LW-1:0] TOPL = LW'(bba_pkg::TOP);

  bba_pkg::bba_state_t state_r, state_nxt, ret_r, ret_nxt;
  logic          en_r;
  logic [31:0]   size_r, size_nxt;
  logic [OW-1:0] p_r, p_nxt, x_r, x_nxt, pnew;
  logic [KW-1:0] h_r, h_nxt, n_r, n_nxt, pr_r, pr_nxt;
  logic [LW-1:0] k_r, k_nxt, want_r, want_nxt, j_r, j_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic [OW-1:0] res_off_r, res_off_nxt;
  logic [LW-1:0] res_lvl_r, res_lvl_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [10:0]   out_data_r;

  logic [bba_pkg::NALLOC-1:0] alloc_r;
  logic [bba_pkg::NSPLIT-1:0] split_r;
  logic [KW-1:0] next_r [bba_pkg::LEAVES];
  logic [KW-1:0] prev_r [bba_pkg::LEAVES];
  logic [KW-1:0] head_r [bba_pkg::LEVELS];
  logic [KW-1:0] nx_rd_r, pv_rd_r;

  // Write strobes into the state tables.
  logic                      an_we, an_val, sp_we, sp_val, nx_we, pv_we, hd_we;
  logic [bba_pkg::AIDX_W-1:0] an_idx;
  logic [bba_pkg::SIDX_W-1:0] sp_idx;
  logic [OW-1:0]             nx_idx, pv_idx;
  logic [LW-1:0]             hd_idx;
  logic [KW-1:0]             nx_val, pv_val, hd_val;

  logic [32:0]   bytes;
  logic [OW-1:0] lowmask;
  logic [LW-1:0] u_lvl;
  logic [OW-1:0] u_off;
  bba_pkg::bba_idx_t idx;

  // Shared index unit.
  assign u_lvl = (state_r == bba_pkg::ST_F_LVL) ? j_r : k_r;
  assign u_off = (state_r == bba_pkg::ST_F_MRG2) ? pnew : p_r;

  bba_idx u_idx (
    .lvl_i (u_lvl),
    .off_i (u_off),
    .idx_o (idx)
  );

  assign bytes   = 33'(LEAF_BYTES) << want_r;
  assign lowmask = ~({OW{1'b1}} << k_r);
  assign pnew    = (x_r[k_r] == 1'b0) ? x_r : p_r;

  assign in_tready  = (state_r == bba_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

  // Sequencer: next state and table writes.
  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;   size_nxt = size_r;
    p_nxt = p_r;   x_nxt = x_r;   h_nxt = h_r;   n_nxt = n_r;   pr_nxt = pr_r;
    k_nxt = k_r;   want_nxt = want_r;   j_nxt = j_r;
    res_ok_nxt = res_ok_r;   res_off_nxt = res_off_r;   res_lvl_nxt = res_lvl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    an_we = 1'b0;  an_idx = '0;  an_val = 1'b0;
    sp_we = 1'b0;  sp_idx = '0;  sp_val = 1'b0;
    nx_we = 1'b0;  nx_idx = '0;  nx_val = '0;
    pv_we = 1'b0;  pv_idx = '0;  pv_val = '0;
    hd_we = 1'b0;  hd_idx = '0;  hd_val = '0;
    unique case (state_r)
      bba_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          size_nxt = in_tdata[31:0];
          p_nxt    = in_tdata[38:32];
          want_nxt = '0;
          j_nxt    = '0;
          res_ok_nxt = 1'b0;  res_off_nxt = '0;  res_lvl_nxt = '0;
          if (in_tuser == bba_pkg::CMD_FREE) state_nxt = bba_pkg::ST_F_LVL;
          else if (!en_r)                    state_nxt = bba_pkg::ST_DONE;
          else                               state_nxt = bba_pkg::ST_A_SIZE;
        end
      end
      // Round the size up one level a cycle.
      bba_pkg::ST_A_SIZE: begin
        if (bytes >= {1'b0, size_r}) begin
          k_nxt = want_r;
          state_nxt = bba_pkg::ST_A_SRCH;
        end else if (want_r == TOPL) begin
          state_nxt = bba_pkg::ST_DONE;
        end else begin
          want_nxt = want_r + 1'b1;
        end
      end
      // Find the lowest non-empty list.
      bba_pkg::ST_A_SRCH: begin
        if (!head_r[k_r][KW-1]) begin
          p_nxt = head_r[k_r][OW-1:0];
          x_nxt = head_r[k_r][OW-1:0];
          ret_nxt = bba_pkg::ST_A_MARK;
          state_nxt = bba_pkg::ST_UNL_A;
        end else if (k_r == TOPL) begin
          state_nxt = bba_pkg::ST_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // Unlink block x from list k; its links were read on the way in.
      bba_pkg::ST_UNL_A: begin
        n_nxt  = nx_rd_r;
        pr_nxt = pv_rd_r;
        if (!pv_rd_r[KW-1]) begin
          nx_we = 1'b1;  nx_idx = pv_rd_r[OW-1:0];  nx_val = nx_rd_r;
        end else begin
          hd_we = 1'b1;  hd_idx = k_r;  hd_val = nx_rd_r;
        end
        pv_we = 1'b1;  pv_idx = x_r;  pv_val = bba_pkg::NIL;
        state_nxt = bba_pkg::ST_UNL_B;
      end
      bba_pkg::ST_UNL_B: begin
        if (!n_r[KW-1]) begin
          pv_we = 1'b1;  pv_idx = n_r[OW-1:0];  pv_val = pr_r;
        end
        nx_we = 1'b1;  nx_idx = x_r;  nx_val = bba_pkg::NIL;
        state_nxt = ret_r;
      end
      bba_pkg::ST_A_MARK: begin
        an_we = 1'b1;  an_idx = idx.a_self;  an_val = 1'b1;
        state_nxt = bba_pkg::ST_A_SPLIT;
      end
      // Split down, pushing each right half.
      bba_pkg::ST_A_SPLIT: begin
        if (k_r > want_r) begin
          sp_we = 1'b1;  sp_idx = idx.s_self;  sp_val = 1'b1;
          an_we = 1'b1;  an_idx = idx.a_low;   an_val = 1'b1;
          k_nxt = k_r - 1'b1;
          x_nxt = p_r + (OW'(1) << (k_r - 1'b1));
          ret_nxt = bba_pkg::ST_A_SPLIT;
          state_nxt = bba_pkg::ST_PUSH_A;
        end else begin
          res_ok_nxt = 1'b1;  res_off_nxt = p_r;  res_lvl_nxt = want_r;
          state_nxt = bba_pkg::ST_DONE;
        end
      end
      // Push block x onto list k.
      bba_pkg::ST_PUSH_A: begin
        h_nxt = head_r[k_r];
        nx_we = 1'b1;  nx_idx = x_r;  nx_val = head_r[k_r];
        pv_we = 1'b1;  pv_idx = x_r;  pv_val = bba_pkg::NIL;
        hd_we = 1'b1;  hd_idx = k_r;  hd_val = {1'b0, x_r};
        state_nxt = bba_pkg::ST_PUSH_B;
      end
      bba_pkg::ST_PUSH_B: begin
        if (!h_r[KW-1]) begin
          pv_we = 1'b1;  pv_idx = h_r[OW-1:0];  pv_val = {1'b0, x_r};
        end
        state_nxt = ret_r;
      end
      // Level of a freed block from the split bits.
      bba_pkg::ST_F_LVL: begin
        if (j_r == TOPL) begin
          k_nxt = TOPL;
          state_nxt = bba_pkg::ST_F_CHK;
        end else if (split_r[idx.s_up]) begin
          k_nxt = j_r;
          state_nxt = bba_pkg::ST_F_CHK;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      bba_pkg::ST_F_CHK: begin
        if ((p_r & lowmask) != '0 || !alloc_r[idx.a_self])
          state_nxt = bba_pkg::ST_DONE;
        else
          state_nxt = bba_pkg::ST_F_MRG;
      end
      // Merge with a free buddy, one level per pass.
      bba_pkg::ST_F_MRG: begin
        if (k_r == TOPL) begin
          state_nxt = bba_pkg::ST_F_END;
        end else begin
          an_we = 1'b1;  an_idx = idx.a_self;  an_val = 1'b0;
          if (alloc_r[idx.a_bud]) begin
            state_nxt = bba_pkg::ST_F_END;
          end else begin
            x_nxt = p_r ^ (OW'(1) << k_r);
            ret_nxt = bba_pkg::ST_F_MRG2;
            state_nxt = bba_pkg::ST_UNL_A;
          end
        end
      end
      bba_pkg::ST_F_MRG2: begin
        p_nxt = pnew;
        sp_we = 1'b1;  sp_idx = idx.s_up;  sp_val = 1'b0;
        k_nxt = k_r + 1'b1;
        state_nxt = bba_pkg::ST_F_MRG;
      end
      bba_pkg::ST_F_END: begin
        an_we = 1'b1;  an_idx = idx.a_self;  an_val = 1'b0;
        x_nxt = p_r;
        ret_nxt = bba_pkg::ST_F_FIN;
        state_nxt = bba_pkg::ST_PUSH_A;
      end
      bba_pkg::ST_F_FIN: begin
        res_ok_nxt = 1'b1;  res_off_nxt = p_r;  res_lvl_nxt = k_r;
        state_nxt = bba_pkg::ST_DONE;
      end
      // Hand the result to the output register once it is free.
      bba_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt = bba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bba_pkg::ST_IDLE;
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::ST_IDLE;
      ret_r       <= bba_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) en_r <= cfg_wr_data;
    end
    size_r <= size_nxt;  p_r <= p_nxt;  x_r <= x_nxt;
    h_r <= h_nxt;  n_r <= n_nxt;  pr_r <= pr_nxt;
    k_r <= k_nxt;  want_r <= want_nxt;  j_r <= j_nxt;
    res_ok_r <= res_ok_nxt;  res_off_r <= res_off_nxt;  res_lvl_r <= res_lvl_nxt;
    // The output register only takes a finished result once it is free.
    if (state_r == bba_pkg::ST_DONE && (!out_valid_r || out_tready))
      out_data_r <= {res_lvl_r, res_off_r, res_ok_r};
  end

  // Bitmaps and free-list tables. Only the first leaf's links need a start
  // value: every other leaf is written by a push before it can be unlinked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r   <= '0;
      split_r   <= '0;
      next_r[0] <= bba_pkg::NIL;
      prev_r[0] <= bba_pkg::NIL;
      for (int i = 0; i < bba_pkg::LEVELS; i++)
        head_r[i] <= (i == bba_pkg::TOP) ? '0 : bba_pkg::NIL;
    end else begin
      if (an_we) alloc_r[an_idx] <= an_val;
      if (sp_we) split_r[sp_idx] <= sp_val;
      if (nx_we) next_r[nx_idx]  <= nx_val;
      if (pv_we) prev_r[pv_idx]  <= pv_val;
      if (hd_we) head_r[hd_idx]  <= hd_val;
    end
    // Registered link read for the block about to be unlinked.
    nx_rd_r <= next_r[x_nxt];
    pv_rd_r <= prev_r[x_nxt];
  end

  // A taken request always starts the sequencer.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != bba_pkg::ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  // A finished result with a free output register is shown next cycle.
  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bba_pkg::ST_DONE && !out_valid_r |=> out_valid_r)
    else $error("result not delivered");

  // A failed request reports a zero offset and level.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[0] |-> out_data_r[10:1] == '0)
    else $error("failed request with nonzero fields");

endmodule

`default_nettype wire

>>> rtl/bba_idx.sv
// ----------------------------------------------------------------------------
// Buddy allocator index unit
// Turns a level and a leaf offset into the bitmap indexes the sequencer needs.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_idx (
  input  wire logic [bba_pkg::LVL_W-1:0] lvl_i,
  input  wire logic [bba_pkg::OFF_W-1:0] off_i,
  output bba_pkg::bba_idx_t              idx_o
);

  int lv;
  int bi;

  // Block of this level, its buddy, its left child and its parent.
  always_comb begin
    lv = int'(lvl_i);
    bi = int'(off_i) >> lv;
    idx_o.a_self = bba_pkg::aidx(lv, bi);
    idx_o.a_bud  = bba_pkg::aidx(lv, bi ^ 1);
    idx_o.a_low  = (lv == 0) ? '0 : bba_pkg::aidx(lv - 1, int'(off_i) >> (lv - 1));
    idx_o.s_self = (lv == 0) ? '0 : bba_pkg::sidx(lv, bi);
    idx_o.s_up   = (lv == bba_pkg::TOP) ? '0 :
                   bba_pkg::sidx(lv + 1, int'(off_i) >> (lv + 1));
  end

endmodule

`default_nettype wire

>>> bench/buddy_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy allocator checker
// Watches the request, result and register channels, keeps its own copy of
// the heap bitmaps and free lists, and compares every result with the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_allocator_checker #(
  parameter int LEAF_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic                      ok;
    logic [bba_pkg::OFF_W-1:0] offset;
    logic [bba_pkg::LVL_W-1:0] level;
  } grant_t;

  logic                       enabled;
  logic                       used_map [bba_pkg::NALLOC];
  logic                       split_map[bba_pkg::NSPLIT];
  logic [bba_pkg::LINK_W-1:0] fwd [bba_pkg::LEAVES];
  logic [bba_pkg::LINK_W-1:0] back[bba_pkg::LEAVES];
  logic [bba_pkg::LINK_W-1:0] head[bba_pkg::LEVELS];
  grant_t                     grants_due[$];

  function automatic int used_at(int k, int bi);
    int i;
    i = (1 << bba_pkg::LEVELS) - (1 << (bba_pkg::LEVELS - k))
        + (bi & ((1 << (bba_pkg::TOP - k)) - 1));
    return (i < bba_pkg::NALLOC) ? i : 0;
  endfunction

  function automatic int split_at(int k, int bi);
    int i;
    i = (1 << bba_pkg::TOP) - (1 << (bba_pkg::LEVELS - k))
        + (bi & ((1 << (bba_pkg::TOP - k)) - 1));
    return (i >= 0 && i < bba_pkg::NSPLIT) ? i : 0;
  endfunction

  function automatic void list_insert(int k, int x);
    logic [bba_pkg::LINK_W-1:0] h;
    h = head[k];
    fwd[x]  = h;
    back[x] = bba_pkg::NIL;
    if (h < bba_pkg::LEAVES) back[h] = bba_pkg::LINK_W'(x);
    head[k] = bba_pkg::LINK_W'(x);
  endfunction

  function automatic void list_drop(int k, int x);
    logic [bba_pkg::LINK_W-1:0] n;
    logic [bba_pkg::LINK_W-1:0] p;
    n = fwd[x];
    p = back[x];
    if (p < bba_pkg::LEAVES) fwd[p] = n;
    else head[k] = n;
    if (n < bba_pkg::LEAVES) back[n] = p;
    fwd[x]  = bba_pkg::NIL;
    back[x] = bba_pkg::NIL;
  endfunction

  task automatic heap_reset();
    enabled = 1'b0;
    for (int i = 0; i < bba_pkg::NALLOC; i++) used_map[i] = 1'b0;
    for (int i = 0; i < bba_pkg::NSPLIT; i++) split_map[i] = 1'b0;
    for (int i = 0; i < bba_pkg::LEAVES; i++) begin
      fwd[i]  = bba_pkg::NIL;
      back[i] = bba_pkg::NIL;
    end
    for (int i = 0; i < bba_pkg::LEVELS; i++) head[i] = bba_pkg::NIL;
    list_insert(bba_pkg::TOP, 0);
  endtask

  // Allocation: round up, take the lowest non-empty list, split downwards.
  function automatic grant_t take_block(logic [31:0] size);
    grant_t     g;
    int         want;
    int         k;
    int         p;
    longint     bytes;
    g = '0;
    want = 0;
    bytes = LEAF_BYTES;
    if (!enabled) return g;
    while (bytes < longint'(size)) begin
      if (want >= bba_pkg::TOP) return g;
      want++;
      bytes = bytes << 1;
    end
    for (k = want; k < bba_pkg::LEVELS; k++) if (head[k] < bba_pkg::LEAVES) break;
    if (k >= bba_pkg::LEVELS) return g;
    p = head[k];
    list_drop(k, p);
    used_map[used_at(k, p >> k)] = 1'b1;
    for (; k > want; k--) begin
      split_map[split_at(k, p >> k)] = 1'b1;
      used_map[used_at(k - 1, p >> (k - 1))] = 1'b1;
      list_insert(k - 1, (p + (1 << (k - 1))) & (bba_pkg::LEAVES - 1));
    end
    g.ok = 1'b1;
    g.offset = bba_pkg::OFF_W'(p);
    g.level = bba_pkg::LVL_W'(want);
    return g;
  endfunction

  // Release: level from the split bits, then merge with free buddies.
  function automatic grant_t give_back(int p);
    grant_t g;
    int     k;
    int     bi;
    int     buddy;
    g = '0;
    k = bba_pkg::TOP;
    for (int j = 0; j < bba_pkg::TOP; j++) begin
      if (split_map[split_at(j + 1, p >> (j + 1))]) begin
        k = j;
        break;
      end
    end
    if ((p & ((1 << k) - 1)) != 0 || !used_map[used_at(k, p >> k)]) return g;
    for (; k < bba_pkg::TOP; k++) begin
      bi = p >> k;
      used_map[used_at(k, bi)] = 1'b0;
      buddy = bi ^ 1;
      if (used_map[used_at(k, buddy)]) break;
      list_drop(k, (buddy << k) & (bba_pkg::LEAVES - 1));
      if ((buddy & 1) == 0) p = (buddy << k) & (bba_pkg::LEAVES - 1);
      split_map[split_at(k + 1, p >> (k + 1))] = 1'b0;
    end
    used_map[used_at(k, p >> k)] = 1'b0;
    list_insert(k, p);
    g.ok = 1'b1;
    g.offset = bba_pkg::OFF_W'(p);
    g.level = bba_pkg::LVL_W'(k);
    return g;
  endfunction

  assign pending = grants_due.size();

  // Predict on accepted requests and compare accepted results.
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (!rst_n) begin
      heap_reset();
      grants_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) enabled = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == bba_pkg::CMD_FREE)
          grants_due.push_back(give_back(int'(in_tdata[38:32])));
        else grants_due.push_back(take_block(in_tdata[31:0]));
      end
      if (out_tvalid && out_tready) begin
        got.ok = out_tdata[0];
        got.offset = out_tdata[7:1];
        got.level = out_tdata[10:8];
        if (grants_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = grants_due.pop_front();
          if (got !== want || out_tdata[15:11] !== '0) begin
            if (fail_count < 10)
              $display("mismatch: expected ok=%0d off=%0d lvl=%0d, got ok=%0d off=%0d lvl=%0d",
                       want.ok, want.offset, want.level, got.ok, got.offset, got.level);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> bench/buddy_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy allocator testbench
// Drives allocate and free requests with random gaps and result stalls,
// toggles the heap enable between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_allocator_test;

  localparam int   STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  int          quiet_cycles = 0;
  logic [6:0]  live_blocks[$];

  always #2 clk = ~clk;

  buddy_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  buddy_allocator_checker u_check (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .fail_count(fail_count), .pending(pending)
  );

  // Remember offsets handed out so that most frees name real blocks.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tdata[0] && $urandom_range(0, 9) != 0)
      live_blocks.push_back(out_tdata[7:1]);
  end

  // Result side: random stall bursts, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (calm || $urandom_range(0, 3) != 0) out_tready <= 1'b1;
    else begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(logic cmd, logic [31:0] size, logic [6:0] offset);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, offset, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_heap(logic on);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [31:0] pick_size();
    int lvl;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'(0);
      default: begin
        lvl = $urandom_range(0, 4);
        return 32'($urandom_range(1, 16 << lvl));
      end
    endcase
  endfunction

  task automatic random_item();
    int idx;
    if (live_blocks.size() > 0 && $urandom_range(0, 9) < 5) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      send(bba_pkg::CMD_FREE, $urandom(), live_blocks[idx]);
      live_blocks.delete(idx);
    end else if ($urandom_range(0, 9) == 0)
      send(bba_pkg::CMD_FREE, $urandom(), 7'($urandom()));
    else send(bba_pkg::CMD_ALLOC, pick_size(), 7'($urandom()));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled heap: allocations fail, frees of unallocated blocks are flagged.
    send(bba_pkg::CMD_ALLOC, 32'd16, 7'd0);
    send(bba_pkg::CMD_FREE, 32'd0, 7'd0);
    settle();
    set_heap(1'b1);

    // Directed: whole heap, too large, size zero, splits, misaligned and
    // double frees, full merge back to the top level.
    send(bba_pkg::CMD_ALLOC, 32'd2048, 7'd0);
    send(bba_pkg::CMD_ALLOC, 32'd1, 7'd0);
    send(bba_pkg::CMD_FREE, 32'd0, 7'd0);
    send(bba_pkg::CMD_ALLOC, 32'd2049, 7'd0);
    send(bba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 7'h7F);
    send(bba_pkg::CMD_ALLOC, 32'd0, 7'd0);
    send(bba_pkg::CMD_ALLOC, 32'd17, 7'd0);
    send(bba_pkg::CMD_ALLOC, 32'd1024, 7'd0);
    send(bba_pkg::CMD_FREE, 32'd0, 7'd3);
    send(bba_pkg::CMD_FREE, 32'd0, 7'd0);
    send(bba_pkg::CMD_FREE, 32'd0, 7'd0);
    send(bba_pkg::CMD_FREE, 32'd0, 7'd2);
    send(bba_pkg::CMD_FREE, 32'd0, 7'd64);
    send(bba_pkg::CMD_FREE, 32'd0, 7'h7F);
    for (int i = 0; i < 8; i++) send(bba_pkg::CMD_ALLOC, 32'd256, 7'd0);
    for (int i = 0; i < 8; i++) send(bba_pkg::CMD_FREE, 32'd0, 7'(i * 16));
    settle();

    // Long result hold-off while requests keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) random_item();
    join
    settle();

    // Random phases with the heap toggled between them.
    for (int ph = 0; ph < 6; ph++) begin
      set_heap(ph != 2);
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 130; i++) random_item();
      settle();
      live_blocks.delete();
      if (ph == 2) begin
        set_heap(1'b1);
        // Free everything still outstanding by sweeping all offsets.
        for (int o = 0; o < bba_pkg::LEAVES; o++) send(bba_pkg::CMD_FREE, 32'd0, 7'(o));
        settle();
      end
    end

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/bba_pkg.sv
rtl/bba_idx.sv
rtl/buddy_allocator.sv
bench/buddy_allocator_checker.sv
bench/buddy_allocator_test.sv
